@@ rtl/outline_to_quadratic_curves_macros.svh @@
// ----------------------------------------------------------------------------
// Outline to quadratic curves: assertion macros
// Clocked, reset-gated property checks used by the checker file.
// ----------------------------------------------------------------------------
`ifndef OUTLINE_TO_QUADRATIC_CURVES_MACROS_SVH
`define OUTLINE_TO_QUADRATIC_CURVES_MACROS_SVH

// Same-cycle implication on clk, off while arst_n is low
`define OTQC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, off while arst_n is low
`define OTQC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/otqc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otqc_pkg
// Transfer types and arithmetic helpers for the outline to quadratic curves
// block.
// ----------------------------------------------------------------------------
package otqc_pkg;

	localparam int CoordW = 16;
	localparam int CountW = 16;

	typedef struct packed {
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
		logic                     on_curve;
		logic                     contour_end;
	} point_t;

	typedef struct packed {
		logic signed [CoordW-1:0] start_x;
		logic signed [CoordW-1:0] start_y;
		logic signed [CoordW-1:0] ctrl_x;
		logic signed [CoordW-1:0] ctrl_y;
		logic signed [CoordW-1:0] end_x;
		logic signed [CoordW-1:0] end_y;
		logic                     closes_contour;
		logic [CountW-1:0]        curve_count;
	} curve_t;

	// Midpoint: widen, add, halve toward zero
	function automatic logic signed [CoordW-1:0] half_sum(
		input logic signed [CoordW-1:0] a,
		input logic signed [CoordW-1:0] b
	);
		logic signed [CoordW:0] s;
		logic signed [CoordW:0] r;
		s = {a[CoordW-1], a} + {b[CoordW-1], b};
		r = s + {{CoordW{1'b0}}, s[CoordW]};
		return r[CoordW:1];
	endfunction

	function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
		return (c == {CountW{1'b1}}) ? c : c + 1'b1;
	endfunction

endpackage

@@ rtl/outline_to_quadratic_curves.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outline_to_quadratic_curves
// Turns a stream of outline points into quadratic curves with implied
// midpoints, straight-segment controls and a counted closing curve.
// ----------------------------------------------------------------------------
// The curves of a point are registered into the output queue when the point
// transfers. One point per cycle while the queue has room; a point that yields
// two curves fills the two-entry queue drained by the single output port.
// A point is taken only when the queue has room for all curves it yields.
// Reset (arst_n low) empties the queue and clears the outline state; the next
// point starts a contour.
module outline_to_quadratic_curves
	import otqc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   point_valid,
	output logic   point_stall,
	input  point_t point,
	output logic   curve_valid,
	input  logic   curve_stall,
	output curve_t curve
);

	logic signed [CoordW-1:0] first_x_q, first_y_q;
	logic signed [CoordW-1:0] anchor_x_q, anchor_y_q;
	logic signed [CoordW-1:0] control_x_q, control_y_q;
	logic                     prev_ctrl_q;
	logic                     expect_first_q;
	logic [CountW-1:0]        curves_q;

	curve_t     buf_q [2];
	logic [1:0] cnt_q;

	logic signed [CoordW-1:0] fx, fy, ax0, ay0, ax1, ay1, cx1, cy1;
	logic signed [CoordW-1:0] mx, my, ctl_x, ctl_y, ctl2_x, ctl2_y;
	logic                     pwc0, pwc1, emit_a, last;
	logic [CountW-1:0]        cc0, cc1, cc2;
	curve_t                   res_a, res_b, r0, r1;
	logic [1:0]               need, free, cnt_d;
	logic                     drain, accept;
	curve_t                   head_d;

	always_comb begin
		fx   = expect_first_q ? point.point_x : first_x_q;
		fy   = expect_first_q ? point.point_y : first_y_q;
		ax0  = expect_first_q ? point.point_x : anchor_x_q;
		ay0  = expect_first_q ? point.point_y : anchor_y_q;
		pwc0 = expect_first_q ? 1'b0 : prev_ctrl_q;
		cc0  = expect_first_q ? '0 : curves_q;
		last = point.contour_end;

		mx    = half_sum(control_x_q, point.point_x);
		my    = half_sum(control_y_q, point.point_y);
		ctl_x = pwc0 ? control_x_q : half_sum(ax0, point.point_x);
		ctl_y = pwc0 ? control_y_q : half_sum(ay0, point.point_y);

		res_a                = '0;
		res_a.start_x        = ax0;
		res_a.start_y        = ay0;
		res_a.closes_contour = 1'b0;
		res_a.curve_count    = '0;

		if (expect_first_q) begin
			emit_a = 1'b0;
			ax1    = point.point_x;
			ay1    = point.point_y;
			cx1    = control_x_q;
			cy1    = control_y_q;
			pwc1   = 1'b0;
			res_a.ctrl_x = control_x_q;
			res_a.ctrl_y = control_y_q;
			res_a.end_x  = point.point_x;
			res_a.end_y  = point.point_y;
		end else if (!point.on_curve) begin
			emit_a = pwc0;
			ax1    = pwc0 ? mx : ax0;
			ay1    = pwc0 ? my : ay0;
			cx1    = point.point_x;
			cy1    = point.point_y;
			pwc1   = 1'b1;
			res_a.ctrl_x = control_x_q;
			res_a.ctrl_y = control_y_q;
			res_a.end_x  = mx;
			res_a.end_y  = my;
		end else begin
			emit_a = 1'b1;
			ax1    = point.point_x;
			ay1    = point.point_y;
			cx1    = ctl_x;
			cy1    = ctl_y;
			pwc1   = 1'b0;
			res_a.ctrl_x = ctl_x;
			res_a.ctrl_y = ctl_y;
			res_a.end_x  = point.point_x;
			res_a.end_y  = point.point_y;
		end

		cc1    = emit_a ? sat_inc(cc0) : cc0;
		cc2    = sat_inc(cc1);
		ctl2_x = pwc1 ? cx1 : half_sum(ax1, fx);
		ctl2_y = pwc1 ? cy1 : half_sum(ay1, fy);

		res_b.start_x        = ax1;
		res_b.start_y        = ay1;
		res_b.ctrl_x         = ctl2_x;
		res_b.ctrl_y         = ctl2_y;
		res_b.end_x          = fx;
		res_b.end_y          = fy;
		res_b.closes_contour = 1'b1;
		res_b.curve_count    = cc2;

		r0 = emit_a ? res_a : res_b;
		r1 = res_b;
	end

	assign need        = {1'b0, emit_a} + {1'b0, last};
	assign curve_valid = (cnt_q != 2'd0);
	assign curve       = buf_q[0];
	assign drain       = curve_valid && !curve_stall;
	assign free        = 2'd2 - cnt_q + {1'b0, drain};
	assign point_stall = (need > free);
	assign accept      = point_valid && !point_stall;
	assign cnt_d       = cnt_q - {1'b0, drain};
	assign head_d      = drain ? buf_q[1] : buf_q[0];

	// advance the output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d + (accept ? need : 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		buf_q[0] <= (accept && cnt_d == 2'd0) ? r0 : head_d;
		if (accept && need != 2'd0) begin
			buf_q[1] <= (cnt_d == 2'd0) ? r1 : r0;
		end
	end

	// update contour state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q      <= '0;
			first_y_q      <= '0;
			anchor_x_q     <= '0;
			anchor_y_q     <= '0;
			control_x_q    <= '0;
			control_y_q    <= '0;
			prev_ctrl_q    <= 1'b0;
			expect_first_q <= 1'b1;
			curves_q       <= '0;
		end else if (accept) begin
			first_x_q <= fx;
			first_y_q <= fy;
			if (last) begin
				anchor_x_q     <= fx;
				anchor_y_q     <= fy;
				control_x_q    <= ctl2_x;
				control_y_q    <= ctl2_y;
				prev_ctrl_q    <= 1'b0;
				expect_first_q <= 1'b1;
				curves_q       <= cc2;
			end else begin
				anchor_x_q     <= ax1;
				anchor_y_q     <= ay1;
				control_x_q    <= cx1;
				control_y_q    <= cy1;
				prev_ctrl_q    <= pwc1;
				expect_first_q <= 1'b0;
				curves_q       <= cc1;
			end
		end
	end

endmodule

@@ rtl/otqc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otqc_checker
// Port-level checks on the curve output of outline_to_quadratic_curves.
// ----------------------------------------------------------------------------
`include "outline_to_quadratic_curves_macros.svh"

module otqc_checker
	import otqc_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   point_valid,
	input logic   point_stall,
	input point_t point,
	input logic   curve_valid,
	input logic   curve_stall,
	input curve_t curve
);

	`OTQC_ASSERT_NEXT(a_curve_hold, curve_valid && curve_stall, curve_valid && $stable(curve), "stalled curve changed")
	`OTQC_ASSERT_NOW(a_open_count, curve_valid && !curve.closes_contour, curve.curve_count == '0, "count on open curve")
	`OTQC_ASSERT_NOW(a_close_count, curve_valid && curve.closes_contour, curve.curve_count != '0, "zero count on closing curve")
	`OTQC_ASSERT_NEXT(a_single_point, point_valid && !point_stall && point.contour_end && !curve_valid, curve_valid, "contour end gave no curve")

endmodule

bind outline_to_quadratic_curves otqc_checker u_otqc_checker (.*);

@@ test/outline_to_quadratic_curves_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outline_to_quadratic_curves_tb
// Streams outline points into the curve decomposer and compares every curve
// it emits against a cycle-free model of the outline state kept here. Covers
// hand-picked contours, a long contour, random contours with idle bursts on
// both channels, a long output stall and a full drain between phases.
// ----------------------------------------------------------------------------
module outline_to_quadratic_curves_tb;
	import otqc_pkg::*;

	localparam int WatchdogLimit = 2000;
	localparam int LongHold = 300;

	logic   clk;
	logic   arst_n;
	logic   point_valid;
	logic   point_stall;
	point_t point;
	logic   curve_valid;
	logic   curve_stall;
	curve_t curve;

	outline_to_quadratic_curves dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.curve_valid(curve_valid),
		.curve_stall(curve_stall),
		.curve(curve)
	);

	always #2 clk = ~clk;

	// Outline state mirrored from the block
	logic signed [CoordW-1:0] first_x, first_y;
	logic signed [CoordW-1:0] anchor_x, anchor_y;
	logic signed [CoordW-1:0] pending_x, pending_y;
	bit                       after_control;
	bit                       contour_open;
	logic [CountW-1:0]        curves_in_contour;

	curve_t expected_curves[$];
	int     mismatch_count;
	int     points_sent;
	int     stall_free_cycles;
	bit     tx_idle_on;
	bit     rx_idle_on;
	int     rx_hold_cycles;

	function automatic logic signed [CoordW-1:0] midpoint(
		input logic signed [CoordW-1:0] a,
		input logic signed [CoordW-1:0] b
	);
		int total;
		total = a + b;
		return CoordW'(total / 2);
	endfunction

	task automatic add_curve(input logic signed [CoordW-1:0] ex,
		input logic signed [CoordW-1:0] ey, input bit closing);
		curve_t c;
		if (curves_in_contour != {CountW{1'b1}})
			curves_in_contour++;
		c.start_x = anchor_x;
		c.start_y = anchor_y;
		c.ctrl_x = pending_x;
		c.ctrl_y = pending_y;
		c.end_x = ex;
		c.end_y = ey;
		c.closes_contour = closing;
		c.curve_count = closing ? curves_in_contour : '0;
		expected_curves.push_back(c);
	endtask

	task automatic predict_curves(input point_t p);
		logic signed [CoordW-1:0] mx, my;
		if (!contour_open) begin
			first_x = p.point_x;
			first_y = p.point_y;
			anchor_x = p.point_x;
			anchor_y = p.point_y;
			after_control = 0;
			curves_in_contour = '0;
			contour_open = 1;
		end else if (!p.on_curve) begin
			if (after_control) begin
				mx = midpoint(pending_x, p.point_x);
				my = midpoint(pending_y, p.point_y);
				add_curve(mx, my, 0);
				anchor_x = mx;
				anchor_y = my;
			end
			pending_x = p.point_x;
			pending_y = p.point_y;
			after_control = 1;
		end else begin
			if (!after_control) begin
				pending_x = midpoint(anchor_x, p.point_x);
				pending_y = midpoint(anchor_y, p.point_y);
			end
			add_curve(p.point_x, p.point_y, 0);
			anchor_x = p.point_x;
			anchor_y = p.point_y;
			after_control = 0;
		end
		if (p.contour_end) begin
			if (!after_control) begin
				pending_x = midpoint(anchor_x, first_x);
				pending_y = midpoint(anchor_y, first_y);
			end
			add_curve(first_x, first_y, 1);
			anchor_x = first_x;
			anchor_y = first_y;
			after_control = 0;
			contour_open = 0;
		end
	endtask

	task automatic note_mismatch(input string field, input logic [CountW-1:0] want,
		input logic [CountW-1:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: curve %s mismatch: expected %h, got %h", $realtime, field, want, got);
	endtask

	// Compare each curve transfer with the oldest expectation
	always @(posedge clk) begin
		curve_t want;
		if (arst_n && curve_valid && !curve_stall) begin
			if (expected_curves.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected curve %p", $realtime, curve);
			end else begin
				want = expected_curves.pop_front();
				if (curve.start_x !== want.start_x)
					note_mismatch("start_x", want.start_x, curve.start_x);
				if (curve.start_y !== want.start_y)
					note_mismatch("start_y", want.start_y, curve.start_y);
				if (curve.ctrl_x !== want.ctrl_x)
					note_mismatch("ctrl_x", want.ctrl_x, curve.ctrl_x);
				if (curve.ctrl_y !== want.ctrl_y)
					note_mismatch("ctrl_y", want.ctrl_y, curve.ctrl_y);
				if (curve.end_x !== want.end_x)
					note_mismatch("end_x", want.end_x, curve.end_x);
				if (curve.end_y !== want.end_y)
					note_mismatch("end_y", want.end_y, curve.end_y);
				if (curve.closes_contour !== want.closes_contour)
					note_mismatch("closes_contour", CountW'(want.closes_contour),
						CountW'(curve.closes_contour));
				if (curve.curve_count !== want.curve_count)
					note_mismatch("curve_count", want.curve_count, curve.curve_count);
			end
		end
	end

	// End the run if nothing transfers for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((point_valid && !point_stall) || (curve_valid && !curve_stall))
				stall_free_cycles <= 0;
			else
				stall_free_cycles <= stall_free_cycles + 1;
			if (stall_free_cycles >= WatchdogLimit) begin
				$display("%0t: timeout, no transfer for %0d cycles", $realtime, WatchdogLimit);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold on request
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles != 0) begin
				curve_stall <= 1'b1;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				curve_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				curve_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	function automatic logic signed [CoordW-1:0] random_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			2: return CoordW'($urandom_range(0, 8) - 4);
			default: return CoordW'($urandom());
		endcase
	endfunction

	task automatic send_point(input logic signed [CoordW-1:0] x,
		input logic signed [CoordW-1:0] y, input bit on, input bit is_end);
		point_t p;
		p = '{x, y, on, is_end};
		point_valid <= 1'b1;
		point <= p;
		do
			@(posedge clk);
		while (point_stall);
		predict_curves(p);
		points_sent++;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			point_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic send_random_contour(input int len);
		bit on;
		for (int i = 0; i < len; i++) begin
			on = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 1) != 0);
			send_point(random_coord(), random_coord(), on, i == len - 1);
		end
	endtask

	task automatic drain_curves();
		point_valid <= 1'b0;
		while (expected_curves.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_directed_shapes();
		tx_idle_on = 0;
		rx_idle_on = 0;
		// single-point contours, on-curve and off-curve
		send_point(16'sh7FFF, 16'sh7FFF, 1, 1);
		send_point(-16'sh8000, -16'sh8000, 0, 1);
		// implied midpoint, straight segment, closing off a control point
		send_point(-16'sh8000, 16'sh7FFF, 1, 0);
		send_point(16'sh7FFF, -16'sh8000, 0, 0);
		send_point(-16'sh8000, -16'sh8000, 0, 0);
		send_point(16'sh7FFF, 16'sh7FFF, 1, 0);
		send_point(-16'sd3, -16'sd2, 1, 0);
		send_point(-16'sd1, 16'sd1, 0, 1);
		// odd negative sums, two curves from an on-curve end point
		send_point(16'sd0, 16'sd0, 1, 0);
		send_point(-16'sd1, -16'sd2, 1, 0);
		send_point(16'sd5, -16'sd5, 0, 0);
		send_point(-16'sh8000, -16'sh8000, 1, 1);
		// off-curve start, run of controls, two curves from an off-curve end
		send_point(16'sd100, -16'sd100, 0, 0);
		send_point(-16'sd7, 16'sd3, 0, 0);
		send_point(16'sd9, -16'sd9, 0, 0);
		send_point(16'sd0, 16'sd1, 0, 1);
		send_point(16'sh7FFF, -16'sh8000, 1, 0);
		send_point(-16'sh8000, 16'sh7FFF, 1, 1);
		drain_curves();
	endtask

	task automatic test_long_contour();
		tx_idle_on = 0;
		rx_idle_on = 0;
		send_random_contour(48);
		drain_curves();
	endtask

	task automatic test_output_hold();
		tx_idle_on = 0;
		rx_idle_on = 0;
		rx_hold_cycles = LongHold;
		repeat (8) send_random_contour($urandom_range(3, 8));
		drain_curves();
	endtask

	task automatic test_random_contours(input int count, input bit idling);
		int target;
		target = points_sent + count;
		tx_idle_on = idling;
		rx_idle_on = idling;
		while (points_sent < target) begin
			send_random_contour($urandom_range(0, 3) == 0 ?
				$urandom_range(1, 3) : $urandom_range(4, 14));
			if ($urandom_range(0, 19) == 0)
				drain_curves();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		point_valid = 1'b0;
		point = '0;
		curve_stall = 1'b0;
		mismatch_count = 0;
		points_sent = 0;
		stall_free_cycles = 0;
		tx_idle_on = 0;
		rx_idle_on = 0;
		rx_hold_cycles = 0;
		contour_open = 0;
		after_control = 0;
		curves_in_contour = '0;
		{first_x, first_y, anchor_x, anchor_y, pending_x, pending_y} = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_shapes();
		test_random_contours(700, 1);
		test_output_hold();
		test_random_contours(550, 1);
		test_long_contour();
		test_random_contours(200, 0);

		drain_curves();
		repeat (8) @(posedge clk);
		if (expected_curves.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
